>>> rtl/zem_pkg.sv
// zem_pkg: shared types, constants and helper functions of the euler to rotation matrix core
package zem_pkg;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int WORK_FRAC = 30;
    localparam int WORK_W = 34;
    localparam int SUM_W = WORK_W + 1;

    localparam longint FULL = 64'sd360 <<< ANGLE_FRAC_BITS;
    localparam longint HALF = 64'sd180 <<< ANGLE_FRAC_BITS;
    localparam longint QUARTER = 64'sd90 <<< ANGLE_FRAC_BITS;
    localparam longint HALF_RND = HALF / 2;
    localparam longint PI_QW = 64'sd3373259426;
    localparam longint PI_Q = PI_QW / HALF;
    localparam longint PI_R = PI_QW % HALF;
    localparam int RECIP_SH = 40;
    localparam longint RECIP = ((64'sd1 <<< RECIP_SH) + HALF - 1) / HALF;
    localparam longint CORDIC_X0 = 64'sd652032874;

    localparam int MAG_W = $clog2(QUARTER + 1);
    localparam int PQ_W = $clog2(QUARTER * PI_Q + 1);
    localparam int XR_W = $clog2(QUARTER * PI_R + HALF / 2 + 1);
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PM_W = XR_W + RECIP_W;
    localparam int Q_W = PM_W - RECIP_SH;
    localparam int RED_W = 18;

    typedef struct packed {
        logic signed [15:0] yaw_deg;
        logic signed [15:0] pitch_deg;
        logic signed [15:0] roll_deg;
    } angles_t;

    typedef struct packed {
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m13;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic signed [15:0] m23;
        logic signed [15:0] m31;
        logic signed [15:0] m32;
        logic signed [15:0] m33;
    } matrix_t;

    typedef struct packed {
        logic signed [WORK_W-1:0] x;
        logic signed [WORK_W-1:0] y;
        logic signed [WORK_W-1:0] z;
        logic flip;
    } lane_t;

    typedef struct packed {
        logic en;
        logic valid;
    } ctrl_t;

    // shift-subtract quotient of two non-negative constants
    function automatic longint div_const(input longint num, input longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--)
        begin
            r = (r <<< 1) | ((num >>> b) & 64'sd1);
            if (r >= den)
            begin
                r = r - den;
                q = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    function automatic longint atan_q(input int i);
        longint acc;
        longint t;
        int k;
        acc = 0;
        if (i == 0)
        begin
            acc = ((PI_QW + 2) >>> 2);
        end
        else
        begin
            for (k = 1; i * k <= WORK_FRAC; k += 2)
            begin
                t = div_const(64'sd1 <<< (WORK_FRAC - i * k), longint'(k));
                if (((k >> 1) & 1) != 0)
                    acc = acc - t;
                else
                    acc = acc + t;
            end
        end
        return acc;
    endfunction

    function automatic logic signed [WORK_W-1:0] mulq(input logic signed [WORK_W-1:0] a,
                                                      input logic signed [WORK_W-1:0] b);
        logic signed [2*WORK_W-1:0] p;
        p = a * b + ((2*WORK_W)'(1) <<< (WORK_FRAC - 1));
        return WORK_W'(p >>> WORK_FRAC);
    endfunction

endpackage

>>> rtl/zem_angle.sv
// zem_angle: wraps and folds the three angles and converts them to radians in q30
module zem_angle import zem_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  ctrl_t         ctrl,
    input  angles_t       angle,
    output logic          valid,
    output lane_t [2:0]   lanes
);

    logic signed [RED_W-1:0] a_in [3];
    logic [MAG_W-1:0] mag_next [3];
    logic neg_next [3];
    logic flip_next [3];

    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic [MAG_W-1:0] mag_reg [3];
    logic a_neg_reg [3], b_neg_reg [3], c_neg_reg [3];
    logic a_flip_reg [3], b_flip_reg [3], c_flip_reg [3];
    logic [PQ_W-1:0] b_pq_reg [3], c_pq_reg [3];
    logic [XR_W-1:0] b_xr_reg [3], c_xr_reg [3];
    logic [PM_W-1:0] c_pm_reg [3];
    lane_t [2:0] lanes_reg;
    lane_t [2:0] lanes_next;

    assign a_in[0] = RED_W'(angle.yaw_deg);
    assign a_in[1] = RED_W'(angle.pitch_deg);
    assign a_in[2] = RED_W'(angle.roll_deg);

    always_comb
    begin
        logic signed [RED_W-1:0] r;
        for (int l = 0; l < 3; l++)
        begin
            r = a_in[l];
            flip_next[l] = 1'b0;
            if (r >= RED_W'(HALF))
                r = r - RED_W'(FULL);
            else if (r < -RED_W'(HALF))
                r = r + RED_W'(FULL);
            if (r > RED_W'(QUARTER))
            begin
                r = RED_W'(HALF) - r;
                flip_next[l] = 1'b1;
            end
            else if (r < -RED_W'(QUARTER))
            begin
                r = -RED_W'(HALF) - r;
                flip_next[l] = 1'b1;
            end
            neg_next[l] = r[RED_W-1];
            mag_next[l] = r[RED_W-1] ? MAG_W'(-r) : MAG_W'(r);
        end
    end

    always_comb
    begin
        logic [Q_W-1:0] q;
        logic [PQ_W:0] zmag;
        for (int l = 0; l < 3; l++)
        begin
            q = Q_W'(c_pm_reg[l] >> RECIP_SH);
            if ((PM_W'(q) * PM_W'(HALF)) > PM_W'(c_xr_reg[l]))
                q = q - Q_W'(1);
            zmag = (PQ_W + 1)'(c_pq_reg[l]) + (PQ_W + 1)'(q);
            lanes_next[l].x = WORK_W'(CORDIC_X0);
            lanes_next[l].y = '0;
            lanes_next[l].z = c_neg_reg[l] ? -WORK_W'(zmag) : WORK_W'(zmag);
            lanes_next[l].flip = c_flip_reg[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (ctrl.en)
        begin
            a_valid_reg <= ctrl.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                mag_reg[l] <= mag_next[l];
                a_neg_reg[l] <= neg_next[l];
                a_flip_reg[l] <= flip_next[l];
                b_pq_reg[l] <= PQ_W'(longint'(mag_reg[l]) * PI_Q);
                b_xr_reg[l] <= XR_W'(longint'(mag_reg[l]) * PI_R + HALF_RND);
                b_neg_reg[l] <= a_neg_reg[l];
                b_flip_reg[l] <= a_flip_reg[l];
                c_pm_reg[l] <= PM_W'(PM_W'(b_xr_reg[l]) * PM_W'(RECIP));
                c_xr_reg[l] <= b_xr_reg[l];
                c_pq_reg[l] <= b_pq_reg[l];
                c_neg_reg[l] <= b_neg_reg[l];
                c_flip_reg[l] <= b_flip_reg[l];
            end
            lanes_reg <= lanes_next;
        end
    end

    assign valid = d_valid_reg;
    assign lanes = lanes_reg;

endmodule

>>> rtl/zem_cordic_cell.sv
// zem_cordic_cell: one cordic rotation step for all three angle lanes
module zem_cordic_cell import zem_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  ctrl_t         ctrl,
    input  lane_t [2:0]   lanes_in,
    output logic          valid,
    output lane_t [2:0]   lanes_out
);

    localparam logic signed [WORK_W-1:0] DA = WORK_W'(atan_q(IDX));

    logic valid_reg;
    lane_t [2:0] lanes_reg;
    lane_t [2:0] lanes_next;

    always_comb
    begin
        logic signed [WORK_W-1:0] dx;
        logic signed [WORK_W-1:0] dy;
        for (int l = 0; l < 3; l++)
        begin
            dx = lanes_in[l].y >>> IDX;
            dy = lanes_in[l].x >>> IDX;
            lanes_next[l].flip = lanes_in[l].flip;
            if (!lanes_in[l].z[WORK_W-1])
            begin
                lanes_next[l].x = lanes_in[l].x - dx;
                lanes_next[l].y = lanes_in[l].y + dy;
                lanes_next[l].z = lanes_in[l].z - DA;
            end
            else
            begin
                lanes_next[l].x = lanes_in[l].x + dx;
                lanes_next[l].y = lanes_in[l].y - dy;
                lanes_next[l].z = lanes_in[l].z + DA;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctrl.en)
            valid_reg <= ctrl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
            lanes_reg <= lanes_next;
    end

    assign valid = valid_reg;
    assign lanes_out = lanes_reg;

endmodule

>>> rtl/zem_matrix.sv
// zem_matrix: forms the nine matrix elements from sines and cosines, rounds and saturates
module zem_matrix import zem_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 14
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  ctrl_t         ctrl,
    input  lane_t [2:0]   lanes,
    output logic          valid,
    output matrix_t       matrix
);

    localparam int SH = WORK_FRAC - OUT_FRAC_BITS;
    localparam int FIN_W = SUM_W + 2;
    localparam logic signed [FIN_W-1:0] RND = (SH == 0) ? '0 : (FIN_W'(1) <<< (SH - 1));
    localparam logic signed [FIN_W-1:0] LIM = FIN_W'(1) <<< OUT_FRAC_BITS;

    function automatic logic signed [15:0] finish(input logic signed [SUM_W-1:0] v);
        logic signed [FIN_W-1:0] t;
        t = (FIN_W'(v) + RND) >>> SH;
        if (t > LIM)
            t = LIM;
        if (t < -LIM)
            t = -LIM;
        return t[15:0];
    endfunction

    logic signed [WORK_W-1:0] sa, ca, sb, cb, sg, cg;

    logic v1_reg, v2_reg, v3_reg;
    logic signed [WORK_W-1:0] casb_reg, sasb_reg, cacb_reg, sacb_reg, sacg_reg, sasg_reg;
    logic signed [WORK_W-1:0] cacg_reg, casg_reg, cbsg_reg, cbcg_reg, sg_reg, cg_reg, sb1_reg;
    logic signed [SUM_W-1:0] e11_reg, e12_reg, e13_reg, e21_reg, e22_reg, e23_reg;
    logic signed [SUM_W-1:0] e31_reg, e32_reg, e33_reg;
    matrix_t matrix_reg;

    assign sa = lanes[0].y;
    assign ca = lanes[0].flip ? -lanes[0].x : lanes[0].x;
    assign sb = lanes[1].y;
    assign cb = lanes[1].flip ? -lanes[1].x : lanes[1].x;
    assign sg = lanes[2].y;
    assign cg = lanes[2].flip ? -lanes[2].x : lanes[2].x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ctrl.en)
        begin
            v1_reg <= ctrl.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            casb_reg <= mulq(ca, sb);
            sasb_reg <= mulq(sa, sb);
            cacb_reg <= mulq(ca, cb);
            sacb_reg <= mulq(sa, cb);
            sacg_reg <= mulq(sa, cg);
            sasg_reg <= mulq(sa, sg);
            cacg_reg <= mulq(ca, cg);
            casg_reg <= mulq(ca, sg);
            cbsg_reg <= mulq(cb, sg);
            cbcg_reg <= mulq(cb, cg);
            sg_reg <= sg;
            cg_reg <= cg;
            sb1_reg <= sb;

            e11_reg <= SUM_W'(cacb_reg);
            e12_reg <= SUM_W'(mulq(casb_reg, sg_reg)) - SUM_W'(sacg_reg);
            e13_reg <= SUM_W'(mulq(casb_reg, cg_reg)) + SUM_W'(sasg_reg);
            e21_reg <= SUM_W'(sacb_reg);
            e22_reg <= SUM_W'(mulq(sasb_reg, sg_reg)) + SUM_W'(cacg_reg);
            e23_reg <= SUM_W'(mulq(sasb_reg, cg_reg)) - SUM_W'(casg_reg);
            e31_reg <= -SUM_W'(sb1_reg);
            e32_reg <= SUM_W'(cbsg_reg);
            e33_reg <= SUM_W'(cbcg_reg);

            matrix_reg.m11 <= finish(e11_reg);
            matrix_reg.m12 <= finish(e12_reg);
            matrix_reg.m13 <= finish(e13_reg);
            matrix_reg.m21 <= finish(e21_reg);
            matrix_reg.m22 <= finish(e22_reg);
            matrix_reg.m23 <= finish(e23_reg);
            matrix_reg.m31 <= finish(e31_reg);
            matrix_reg.m32 <= finish(e32_reg);
            matrix_reg.m33 <= finish(e33_reg);
        end
    end

    assign valid = v3_reg;
    assign matrix = matrix_reg;

endmodule

>>> rtl/zyx_euler_to_rotation_matrix_core.sv
// zyx_euler_to_rotation_matrix_core: top level of the zyx euler angle to rotation matrix core
//
// angle channel: yaw, pitch and roll in degrees with 6 fraction bits, any 16-bit
// pattern, wrapped modulo 360 degrees. a transfer happens when angle_valid is high
// and angle_stall is low.
// matrix channel: the nine elements of rz*ry*rx as signed q1.14 values saturated
// at +-2^OUT_FRAC_BITS, one transfer per angle transfer, in order.
// the steps are angle folding and radian conversion, then TRIG_STAGES cordic
// cells with one cell per stage, then products, sums and rounding. throughput
// is one item per cycle while the matrix side does not stall; the pipeline is
// fully pipelined and every stage takes a new item each cycle unless it holds.
// when the matrix side stalls with a result waiting, the whole pipeline holds and
// angle_stall is raised; every stage holds, empty ones included.
// reset clears all valid flags; payload registers are not reset.
module zyx_euler_to_rotation_matrix_core import zem_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 14,
    parameter int TRIG_STAGES = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    angle_valid,
    output logic    angle_stall,
    input  angles_t angle,
    output logic    matrix_valid,
    input  logic    matrix_stall,
    output matrix_t matrix
);

    logic en;
    logic ang_valid;
    lane_t [2:0] ang_lanes;
    logic cell_valid [TRIG_STAGES+1];
    lane_t [2:0] cell_lanes [TRIG_STAGES+1];

    assign en = !(matrix_valid && matrix_stall);
    assign angle_stall = !en;

    zem_angle u_angle
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  ('{en: en, valid: angle_valid}),
        .angle (angle),
        .valid (ang_valid),
        .lanes (ang_lanes)
    );

    assign cell_valid[0] = ang_valid;
    assign cell_lanes[0] = ang_lanes;

    for (genvar i = 0; i < TRIG_STAGES; i++)
    begin : g_cell
        zem_cordic_cell #(.IDX(i)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      ('{en: en, valid: cell_valid[i]}),
            .lanes_in  (cell_lanes[i]),
            .valid     (cell_valid[i+1]),
            .lanes_out (cell_lanes[i+1])
        );
    end

    zem_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_matrix
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   ('{en: en, valid: cell_valid[TRIG_STAGES]}),
        .lanes  (cell_lanes[TRIG_STAGES]),
        .valid  (matrix_valid),
        .matrix (matrix)
    );

endmodule

>>> rtl/zem_checker.sv
// zem_checker: port assertions for the euler to rotation matrix core and its bind
module zem_checker import zem_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 14
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    angle_valid,
    input logic    angle_stall,
    input angles_t angle,
    input logic    matrix_valid,
    input logic    matrix_stall,
    input matrix_t matrix
);

    localparam logic signed [15:0] LIM = 16'(1 << (OUT_FRAC_BITS < 15 ? OUT_FRAC_BITS : 14));

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        matrix_valid && matrix_stall |=> matrix_valid && $stable(matrix))
        else $error("stalled matrix transfer changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && angle_stall |=> angle_valid && $stable(angle))
        else $error("stalled angle transfer changed");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        angle_stall |-> matrix_valid && matrix_stall)
        else $error("angle stall without a stalled result");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        matrix_valid && OUT_FRAC_BITS <= 14 |->
            matrix.m31 <= LIM && matrix.m31 >= -LIM &&
            matrix.m11 <= LIM && matrix.m11 >= -LIM &&
            matrix.m33 <= LIM && matrix.m33 >= -LIM)
        else $error("matrix element beyond saturation limit");

    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !matrix_valid |-> !angle_stall)
        else $error("input stalled while output empty");

endmodule

bind zyx_euler_to_rotation_matrix_core zem_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .angle_valid  (angle_valid),
    .angle_stall  (angle_stall),
    .angle        (angle),
    .matrix_valid (matrix_valid),
    .matrix_stall (matrix_stall),
    .matrix       (matrix)
);
